@@ design/mips_hi_lo_multiply_divide_unit_macros.svh @@
// assertion macros shared by the multiply/divide unit files
`ifndef MIPS_HI_LO_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`define MIPS_HI_LO_MULTIPLY_DIVIDE_UNIT_MACROS_SVH

// same-cycle implication
`define MDU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MDU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mdu_pkg.sv @@
// types and constants of the multiply/divide unit
package mdu_pkg;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 5;

   // operation codes carried in the request
   typedef enum logic [2:0] {
      OP_MULT  = 3'd0,
      OP_MULTU = 3'd1,
      OP_DIV   = 3'd2,
      OP_DIVU  = 3'd3,
      OP_MTHI  = 3'd4,
      OP_MTLO  = 3'd5,
      OP_MFHI  = 3'd6,
      OP_MFLO  = 3'd7
   } op_type;

   // sequencer states of the shared arithmetic engine
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_NEG_N,
      ST_DIV_NEG_D,
      ST_DIV_STEP,
      ST_DIV_FIX_Q,
      ST_DIV_FIX_R,
      ST_MUL_STEP
   } state_type;

   // command from the front end to the engine
   typedef struct packed {
      logic                start;
      op_type              op;
      logic [WORD_W-1:0]   rs_value;
      logic [WORD_W-1:0]   rt_value;
   } mdu_cmd_type;

   // engine status back to the front end
   typedef struct packed {
      logic                busy;
      logic [WORD_W-1:0]   hi_word;
      logic [WORD_W-1:0]   lo_word;
   } mdu_status_type;

endpackage

@@ design/mdu_engine.sv @@
// hi/lo registers with an iterative shift-add multiplier and restoring divider
`include "mips_hi_lo_multiply_divide_unit_macros.svh"

module mdu_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  mdu_pkg::mdu_cmd_type    cmd,
   output mdu_pkg::mdu_status_type status
);
   import mdu_pkg::*;

   localparam logic [COUNT_W-1:0] STEP_LAST = '1;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [WORD_W:0]      acc_ff, acc_in;
   logic [WORD_W-1:0]    lo_ff, lo_in;
   logic [WORD_W-1:0]    opnd_ff, opnd_in;
   logic                 sgn_ff, sgn_in;
   logic                 neg_q_ff, neg_q_in;
   logic                 neg_r_ff, neg_r_in;

   // shared adder/subtractor
   logic [WORD_W+1:0]    add_a, add_b, add_sum;
   logic                 add_sub;
   logic                 step_last;

   assign add_sum   = add_sub ? (add_a - add_b) : (add_a + add_b);
   assign step_last = (count_ff == STEP_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               if (cmd.op == OP_MULT || cmd.op == OP_MULTU) begin
                  state_in = ST_MUL_STEP;
               end else if (cmd.op == OP_DIV || cmd.op == OP_DIVU) begin
                  state_in = ST_DIV_NEG_N;
               end
            end
         end
         ST_DIV_NEG_N: state_in = ST_DIV_NEG_D;
         ST_DIV_NEG_D: state_in = ST_DIV_STEP;
         ST_DIV_STEP: begin
            if (step_last) begin
               state_in = ST_DIV_FIX_Q;
            end
         end
         ST_DIV_FIX_Q: state_in = ST_DIV_FIX_R;
         ST_DIV_FIX_R: state_in = ST_IDLE;
         ST_MUL_STEP: begin
            if (step_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and register updates
   always_comb begin
      logic qbit;
      qbit     = 1'b0;
      acc_in   = acc_ff;
      lo_in    = lo_ff;
      opnd_in  = opnd_ff;
      sgn_in   = sgn_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      count_in = '0;
      add_a    = '0;
      add_b    = '0;
      add_sub  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               unique case (cmd.op)
                  OP_MULT, OP_MULTU: begin
                     acc_in  = '0;
                     lo_in   = cmd.rt_value;
                     opnd_in = cmd.rs_value;
                     sgn_in  = (cmd.op == OP_MULT);
                  end
                  OP_DIV, OP_DIVU: begin
                     acc_in   = '0;
                     lo_in    = cmd.rs_value;
                     opnd_in  = cmd.rt_value;
                     sgn_in   = (cmd.op == OP_DIV);
                     neg_q_in = (cmd.op == OP_DIV) &&
                                (cmd.rs_value[WORD_W-1] ^ cmd.rt_value[WORD_W-1]);
                     neg_r_in = (cmd.op == OP_DIV) && cmd.rs_value[WORD_W-1];
                  end
                  OP_MTHI: acc_in = {1'b0, cmd.rs_value};
                  OP_MTLO: lo_in  = cmd.rs_value;
                  OP_MFHI, OP_MFLO: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         // dividend magnitude
         ST_DIV_NEG_N: begin
            add_b   = {2'b00, lo_ff};
            add_sub = 1'b1;
            if (sgn_ff && lo_ff[WORD_W-1]) begin
               lo_in = add_sum[WORD_W-1:0];
            end
         end
         // divisor magnitude
         ST_DIV_NEG_D: begin
            add_b   = {2'b00, opnd_ff};
            add_sub = 1'b1;
            if (sgn_ff && opnd_ff[WORD_W-1]) begin
               opnd_in = add_sum[WORD_W-1:0];
            end
         end
         // one quotient bit per cycle, restoring
         ST_DIV_STEP: begin
            add_a   = {1'b0, acc_ff[WORD_W-1:0], lo_ff[WORD_W-1]};
            add_b   = {2'b00, opnd_ff};
            add_sub = 1'b1;
            if (!add_sum[WORD_W+1]) begin
               acc_in = add_sum[WORD_W:0];
               qbit   = 1'b1;
            end else begin
               acc_in = add_a[WORD_W:0];
            end
            lo_in    = {lo_ff[WORD_W-2:0], qbit};
            count_in = count_ff + 1'b1;
         end
         // quotient sign
         ST_DIV_FIX_Q: begin
            add_b   = {2'b00, lo_ff};
            add_sub = 1'b1;
            if (neg_q_ff) begin
               lo_in = add_sum[WORD_W-1:0];
            end
         end
         // remainder takes the dividend sign
         ST_DIV_FIX_R: begin
            add_b   = {2'b00, acc_ff[WORD_W-1:0]};
            add_sub = 1'b1;
            if (neg_r_ff) begin
               acc_in = {1'b0, add_sum[WORD_W-1:0]};
            end
         end
         // one multiplier bit per cycle, last signed bit has negative weight
         ST_MUL_STEP: begin
            add_a = {acc_ff[WORD_W] & sgn_ff, acc_ff};
            if (lo_ff[0]) begin
               add_b = {{2{opnd_ff[WORD_W-1] & sgn_ff}}, opnd_ff};
            end
            add_sub  = sgn_ff && step_last;
            acc_in   = {sgn_ff & add_sum[WORD_W], add_sum[WORD_W:1]};
            lo_in    = {add_sum[0], lo_ff[WORD_W-1:1]};
            count_in = count_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         acc_ff   <= '0;
         lo_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         lo_ff    <= lo_in;
      end
   end

   // operand and sign registers
   always_ff @(posedge clock) begin
      opnd_ff  <= opnd_in;
      sgn_ff   <= sgn_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign status.busy    = (state_ff != ST_IDLE);
   assign status.hi_word = acc_ff[WORD_W-1:0];
   assign status.lo_word = lo_ff;

   `MDU_ASSERT_IMP(a_idle_count, clock, reset, state_ff == ST_IDLE, count_ff == '0,
      "step counter not clear when idle")
   `MDU_ASSERT_NXT(a_div_done, clock, reset, state_ff == ST_DIV_STEP && step_last,
      state_ff == ST_DIV_FIX_Q, "divide did not finish after last step")
   `MDU_ASSERT_NXT(a_mul_start, clock, reset,
      state_ff == ST_IDLE && cmd.start && (cmd.op == OP_MULT || cmd.op == OP_MULTU),
      state_ff == ST_MUL_STEP, "multiply did not start")

endmodule

@@ design/mips_hi_lo_multiply_divide_unit.sv @@
// top level of the mips hi/lo multiply/divide unit
// Usage:
//   req channel (req_tvalid/req_tready/req_tdata) carries one request:
//   an operation code and two 32-bit source values. rsp channel
//   (rsp_tvalid/rsp_tready/rsp_tdata) returns one 32-bit word per request:
//   hi or lo for the read operations, zero for all others.
//   A response appears in the cycle after its request is accepted and is held
//   in an output register until taken; while it waits the next request may
//   still be accepted, as long as that register is being emptied.
//   Moves and reads occupy the unit for the accepting cycle only.
//   Multiplies run one multiplier bit per cycle through a shared 34-bit
//   adder. Divides use the same adder: dividend and divisor magnitudes,
//   the restoring quotient-bit steps, then quotient and remainder sign
//   fix-up.
//   req_tready is low while the adder loop runs.
//   Reset clears hi, lo, the sequencer and the output valid flag.
//   A stalled rsp_tready holds the response and, once the output register
//   is full, holds req_tready low.
`include "mips_hi_lo_multiply_divide_unit_macros.svh"

module mips_hi_lo_multiply_divide_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // op[2:0], rs_value[34:3], rt_value[66:35], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // read_value[31:0]
);
   import mdu_pkg::*;

   mdu_cmd_type         cmd;
   mdu_status_type      status;
   logic                req_accept;
   op_type              req_op;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_data_ff, rsp_data_in;

   assign req_op     = op_type'(req_tdata[2:0]);
   assign req_tready = !status.busy && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   // command to the engine
   assign cmd.start    = req_accept;
   assign cmd.op       = req_op;
   assign cmd.rs_value = req_tdata[34:3];
   assign cmd.rt_value = req_tdata[66:35];

   mdu_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         unique case (req_op)
            OP_MFHI: rsp_data_in = status.hi_word;
            OP_MFLO: rsp_data_in = status.lo_word;
            default: rsp_data_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MDU_ASSERT_NXT(a_rsp_after_req, clock, reset, req_accept, rsp_valid_ff,
      "no response after accepted request")
   `MDU_ASSERT_NXT(a_busy_after_arith, clock, reset,
      req_accept && (req_op == OP_MULT || req_op == OP_MULTU || req_op == OP_DIV ||
      req_op == OP_DIVU), status.busy && !req_tready, "engine not busy after arithmetic request")
   `MDU_ASSERT_NXT(a_zero_non_read, clock, reset,
      req_accept && req_op != OP_MFHI && req_op != OP_MFLO, rsp_data_ff == '0,
      "non-read request gave non-zero response")

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench of the mips hi/lo multiply/divide unit
`timescale 1ns / 100ps

module tb_top;
   import mdu_pkg::*;

   localparam int RANDOM_REQS = 1850;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 60;

   // one request as the driver sees it
   typedef struct {
      op_type      op;
      logic [31:0] rs_value;
      logic [31:0] rt_value;
   } mdu_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // op[2:0], rs_value[34:3], rt_value[66:35], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // read_value[31:0]

   mdu_req_type pending_reqs[$];
   logic [31:0] expected_reads[$];
   logic [31:0] hi_model = '0;
   logic [31:0] lo_model = '0;
   logic        req_fire = 1'b0;
   int          burst_left = 1;
   int          gap_left = 0;
   logic [15:0] ready_pattern = 16'hffff;
   int          pattern_age = 0;
   int          mismatches = 0;
   int          checked = 0;
   int          cycles = 0;
   int          op_count[8];

   mips_hi_lo_multiply_divide_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock and reset
   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // signed operands as magnitudes
   function automatic logic [31:0] magnitude_of(logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   // applies one request to the hi/lo copy and returns the word it reads back
   function automatic logic [31:0] apply_request(op_type op, logic [31:0] rs, logic [31:0] rt);
      logic [63:0] prod;
      logic [31:0] qm;
      logic [31:0] rm;
      logic [31:0] read_word;
      read_word = '0;
      case (op)
         OP_MULT: begin
            prod = {{32{rs[31]}}, rs} * {{32{rt[31]}}, rt};
            {hi_model, lo_model} = prod;
         end
         OP_MULTU: begin
            prod = {32'd0, rs} * {32'd0, rt};
            {hi_model, lo_model} = prod;
         end
         OP_DIV: begin
            if (rt == 32'd0) begin
               // divide by zero: quotient by dividend sign, remainder is dividend
               lo_model = rs[31] ? 32'd1 : 32'hffffffff;
               hi_model = rs;
            end else if (rs == 32'h80000000 && rt == 32'hffffffff) begin
               // most negative over minus one wraps
               lo_model = 32'h80000000;
               hi_model = 32'd0;
            end else begin
               qm = magnitude_of(rs) / magnitude_of(rt);
               rm = magnitude_of(rs) % magnitude_of(rt);
               lo_model = (rs[31] != rt[31]) ? (32'd0 - qm) : qm;
               hi_model = rs[31] ? (32'd0 - rm) : rm;
            end
         end
         OP_DIVU: begin
            if (rt == 32'd0) begin
               lo_model = 32'hffffffff;
               hi_model = rs;
            end else begin
               lo_model = rs / rt;
               hi_model = rs % rt;
            end
         end
         OP_MTHI: hi_model = rs;
         OP_MTLO: lo_model = rs;
         OP_MFHI: read_word = hi_model;
         default: read_word = lo_model;
      endcase
      return read_word;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hffffffff;
         3: return 32'h80000000;
         4: return 32'h7fffffff;
         5: return $urandom_range(0, 15);
         6: return 32'd0 - $urandom_range(1, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_req(op_type op, logic [31:0] rs, logic [31:0] rt);
      mdu_req_type item;
      item.op = op;
      item.rs_value = rs;
      item.rt_value = rt;
      pending_reqs.push_back(item);
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   // request driver: bursts of requests separated by random gaps
   always @(negedge clock) begin
      mdu_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // hold the request until it is taken
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         item = pending_reqs.pop_front();
         req_tvalid <= 1'b1;
         req_tdata <= {5'd0, item.rt_value, item.rs_value, item.op};
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            case ($urandom_range(0, 3))
               0: gap_left <= 0;
               1: gap_left <= $urandom_range(1, 40);
               default: gap_left <= $urandom_range(1, 6);
            endcase
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_tvalid <= 1'b0;
      end

      // response stall pattern, reloaded now and then
      if (pattern_age == 63) begin
         pattern_age <= 0;
         case ($urandom_range(0, 2))
            0: ready_pattern <= 16'hffff;
            default: ready_pattern <= 16'($urandom) | 16'h0001;
         endcase
      end else begin
         pattern_age <= pattern_age + 1;
         ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
      end
      rsp_tready <= !reset && ready_pattern[0];
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      logic [31:0] expected_word;
      cycles <= cycles + 1;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (expected_reads.size() == 0) begin
               report_mismatch($sformatf("response %08h with no request waiting", rsp_tdata));
            end else begin
               expected_word = expected_reads.pop_front();
               if (rsp_tdata !== expected_word)
                  report_mismatch($sformatf("read_value %08h, expected %08h",
                                            rsp_tdata, expected_word));
            end
         end
         if (req_tvalid && req_tready) begin
            op_count[req_tdata[2:0]]++;
            expected_reads.push_back(apply_request(op_type'(req_tdata[2:0]),
                                                   req_tdata[34:3], req_tdata[66:35]));
         end
      end
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int count;
      op_type arith_op;
      count = 0;

      // directed: reset state, extremes and the divide corner cases
      queue_req(OP_MFHI, 32'hffffffff, 32'hffffffff);
      queue_req(OP_MFLO, 32'd0, 32'd0);
      queue_req(OP_MULT, 32'h80000000, 32'h80000000);
      queue_req(OP_MFHI, 32'd0, 32'd0);
      queue_req(OP_MFLO, 32'd0, 32'd0);
      queue_req(OP_MULTU, 32'hffffffff, 32'hffffffff);
      queue_req(OP_MFHI, 32'd0, 32'd0);
      queue_req(OP_MFLO, 32'd0, 32'd0);
      queue_req(OP_MULT, 32'hffffffff, 32'h7fffffff);
      queue_req(OP_MFHI, 32'd0, 32'd0);
      queue_req(OP_DIV, 32'h80000000, 32'hffffffff);
      queue_req(OP_MFHI, 32'd0, 32'd0);
      queue_req(OP_MFLO, 32'd0, 32'd0);
      queue_req(OP_DIV, 32'hfffffff9, 32'd2);
      queue_req(OP_MFHI, 32'd0, 32'd0);
      queue_req(OP_MFLO, 32'd0, 32'd0);
      queue_req(OP_DIV, 32'h80000001, 32'd0);
      queue_req(OP_MFLO, 32'd0, 32'd0);
      queue_req(OP_DIV, 32'h7fffffff, 32'd0);
      queue_req(OP_MFLO, 32'd0, 32'd0);
      queue_req(OP_DIVU, 32'hfedcba98, 32'd0);
      queue_req(OP_MFHI, 32'd0, 32'd0);
      queue_req(OP_MTHI, 32'hffffffff, 32'h12345678);
      queue_req(OP_MTLO, 32'd0, 32'hffffffff);
      queue_req(OP_MFHI, 32'd0, 32'd0);
      queue_req(OP_MFLO, 32'hffffffff, 32'hffffffff);

      // random: mostly an update followed by reads, the rest single requests
      while (count < RANDOM_REQS) begin
         if ($urandom_range(0, 99) < 70) begin
            arith_op = op_type'($urandom_range(0, 5));
            queue_req(arith_op, pick_operand(), pick_operand());
            count++;
            if ($urandom_range(0, 1)) begin
               queue_req(OP_MFHI, $urandom, $urandom);
               queue_req(OP_MFLO, $urandom, $urandom);
            end else begin
               queue_req(OP_MFLO, $urandom, $urandom);
               queue_req(OP_MFHI, $urandom, $urandom);
            end
            count += 2;
         end else begin
            queue_req(op_type'($urandom_range(0, 7)), pick_operand(), pick_operand());
            count++;
         end
      end

      @(negedge clock);
      while (reset || pending_reqs.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_reads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("requests: mult %0d, multu %0d, div %0d, divu %0d, mthi %0d, mtlo %0d",
               op_count[OP_MULT], op_count[OP_MULTU], op_count[OP_DIV],
               op_count[OP_DIVU], op_count[OP_MTHI], op_count[OP_MTLO]);
      $display("reads: mfhi %0d, mflo %0d; %0d responses checked, %0d mismatches",
               op_count[OP_MFHI], op_count[OP_MFLO], checked, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
